[hdl/pdc_pkg.sv]
// pdc_pkg: shared widths, register indexes, microcode types and the control store
// of the PID drive controller. No dependencies.
`default_nettype none

package pdc_pkg;

    // measured input is clamped to +/- this value
    localparam int MEAS_LIMIT = 100;

    localparam int IN_W    = 16;
    localparam int GAIN_W  = 40;
    localparam int HALF_W  = GAIN_W / 2;
    localparam int WL_W    = 20;
    localparam int NS_W    = 10;
    localparam int OL_W    = 15;
    localparam int ERR_W   = 18;
    localparam int DLT_W   = ERR_W + 1;
    localparam int INT_W   = WL_W + 1;
    localparam int PRE_W   = INT_W + 1;
    localparam int MA_W    = HALF_W + 1;
    localparam int MB_W    = PRE_W;
    localparam int PROD_W  = MA_W + MB_W;
    localparam int ACC_W   = 64;
    localparam int USAT_W  = 41;
    localparam int DRV_W   = 32;
    localparam int FRAC_Q  = 16;
    localparam int FLOOR_SH = 8;
    localparam int CIDX_W  = 3;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] REG_KP     = 3'd0;
    localparam logic [CIDX_W-1:0] REG_KI_DT  = 3'd1;
    localparam logic [CIDX_W-1:0] REG_KD_DT  = 3'd2;
    localparam logic [CIDX_W-1:0] REG_WL     = 3'd3;
    localparam logic [CIDX_W-1:0] REG_WR     = 3'd4;
    localparam logic [CIDX_W-1:0] REG_NS     = 3'd5;
    localparam logic [CIDX_W-1:0] REG_OL     = 3'd6;

    typedef struct packed {
        logic [GAIN_W-1:0] kp_gain;
        logic [GAIN_W-1:0] ki_dt_gain;
        logic [GAIN_W-1:0] kd_over_dt_gain;
        logic [WL_W-1:0]   windup_limit;
        logic [WL_W-1:0]   windup_reload;
        logic [NS_W-1:0]   neg_scale;
        logic [OL_W-1:0]   out_limit;
    } cfg_t;

    typedef logic [3:0] step_t;

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_LOAD,
        OP_MAC,
        OP_FLOOR,
        OP_DONE
    } op_t;

    typedef enum logic [2:0] {
        A_KP_HI,
        A_KP_LO,
        A_KI_HI,
        A_KI_LO,
        A_KD_HI,
        A_KD_LO,
        A_NS
    } asel_t;

    typedef enum logic [2:0] {
        B_ERR,
        B_SUM,
        B_DLT,
        B_U_HI,
        B_U_LO
    } bsel_t;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_WAIT_IN,
        JMP_IF_NONNEG,
        JMP_WAIT_OUT
    } jmp_t;

    typedef struct packed {
        op_t   op;
        asel_t a_sel;
        bsel_t b_sel;
        logic  hi;      // product weighted by 2^HALF_W
        logic  clr;     // product replaces the accumulator
        jmp_t  jmp;
        step_t target;
    } ctrl_t;

    typedef struct packed {
        logic acc_neg;
        logic out_free;
    } stat_t;

    localparam step_t S_IDLE  = 4'd0;
    localparam step_t S_LOAD  = 4'd1;
    localparam step_t S_KP_HI = 4'd2;
    localparam step_t S_KP_LO = 4'd3;
    localparam step_t S_KI_HI = 4'd4;
    localparam step_t S_KI_LO = 4'd5;
    localparam step_t S_KD_HI = 4'd6;
    localparam step_t S_KD_LO = 4'd7;
    localparam step_t S_FLOOR = 4'd8;
    localparam step_t S_NS_HI = 4'd9;
    localparam step_t S_NS_LO = 4'd10;
    localparam step_t S_DONE  = 4'd11;

    function automatic ctrl_t cw(input op_t op, input asel_t a, input bsel_t b,
                                 input logic hi, input logic clr, input jmp_t j,
                                 input step_t t);
        ctrl_t w;
        w.op     = op;
        w.a_sel  = a;
        w.b_sel  = b;
        w.hi     = hi;
        w.clr    = clr;
        w.jmp    = j;
        w.target = t;
        return w;
    endfunction

    // control store
    function automatic ctrl_t ucode(input step_t s);
        ctrl_t w;
        case (s)
            S_IDLE:  w = cw(OP_IDLE,  A_KP_LO, B_ERR,  1'b0, 1'b0, JMP_WAIT_IN,   S_IDLE);
            S_LOAD:  w = cw(OP_LOAD,  A_KP_LO, B_ERR,  1'b0, 1'b0, JMP_NEXT,      S_IDLE);
            S_KP_HI: w = cw(OP_MAC,   A_KP_HI, B_ERR,  1'b1, 1'b1, JMP_NEXT,      S_IDLE);
            S_KP_LO: w = cw(OP_MAC,   A_KP_LO, B_ERR,  1'b0, 1'b0, JMP_NEXT,      S_IDLE);
            S_KI_HI: w = cw(OP_MAC,   A_KI_HI, B_SUM,  1'b1, 1'b0, JMP_NEXT,      S_IDLE);
            S_KI_LO: w = cw(OP_MAC,   A_KI_LO, B_SUM,  1'b0, 1'b0, JMP_NEXT,      S_IDLE);
            S_KD_HI: w = cw(OP_MAC,   A_KD_HI, B_DLT,  1'b1, 1'b0, JMP_NEXT,      S_IDLE);
            S_KD_LO: w = cw(OP_MAC,   A_KD_LO, B_DLT,  1'b0, 1'b0, JMP_NEXT,      S_IDLE);
            S_FLOOR: w = cw(OP_FLOOR, A_KP_LO, B_ERR,  1'b0, 1'b0, JMP_IF_NONNEG, S_DONE);
            S_NS_HI: w = cw(OP_MAC,   A_NS,    B_U_HI, 1'b1, 1'b1, JMP_NEXT,      S_IDLE);
            S_NS_LO: w = cw(OP_MAC,   A_NS,    B_U_LO, 1'b0, 1'b0, JMP_NEXT,      S_IDLE);
            S_DONE:  w = cw(OP_DONE,  A_KP_LO, B_ERR,  1'b0, 1'b0, JMP_WAIT_OUT,  S_IDLE);
            default: w = cw(OP_IDLE,  A_KP_LO, B_ERR,  1'b0, 1'b0, JMP_NEXT,      S_IDLE);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[hdl/pdc_cfg_regs.sv]
// pdc_cfg_regs: configuration register file of the PID drive controller.
// Depends on pdc_pkg.
`default_nettype none

module pdc_cfg_regs (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [pdc_pkg::CIDX_W-1:0] cfg_index,
    input  wire logic [pdc_pkg::GAIN_W-1:0] cfg_data,
    output pdc_pkg::cfg_t                   cfg
);

    pdc_pkg::cfg_t cfg_reg;
    pdc_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                pdc_pkg::REG_KP:    cfg_next.kp_gain         = cfg_data;
                pdc_pkg::REG_KI_DT: cfg_next.ki_dt_gain      = cfg_data;
                pdc_pkg::REG_KD_DT: cfg_next.kd_over_dt_gain = cfg_data;
                pdc_pkg::REG_WL:    cfg_next.windup_limit    = cfg_data[pdc_pkg::WL_W-1:0];
                pdc_pkg::REG_WR:    cfg_next.windup_reload   = cfg_data[pdc_pkg::WL_W-1:0];
                pdc_pkg::REG_NS:    cfg_next.neg_scale       = cfg_data[pdc_pkg::NS_W-1:0];
                pdc_pkg::REG_OL:    cfg_next.out_limit       = cfg_data[pdc_pkg::OL_W-1:0];
                default:            cfg_next = cfg_reg;   // unknown index: dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp_gain         <= 40'd8388608;
            cfg_reg.ki_dt_gain      <= 40'd3355;
            cfg_reg.kd_over_dt_gain <= 40'd0;
            cfg_reg.windup_limit    <= 20'd3000;
            cfg_reg.windup_reload   <= 20'd1000;
            cfg_reg.neg_scale       <= 10'd384;
            cfg_reg.out_limit       <= 15'd100;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

[hdl/pdc_sequencer.sv]
// pdc_sequencer: step counter and control store lookup with conditional jumps.
// Depends on pdc_pkg.
`default_nettype none

module pdc_sequencer (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire pdc_pkg::stat_t  status,
    output pdc_pkg::ctrl_t       ctrl,
    output logic                 busy
);

    pdc_pkg::step_t pc_reg;
    pdc_pkg::step_t pc_next;

    assign ctrl = pdc_pkg::ucode(pc_reg);
    assign busy = (pc_reg != pdc_pkg::S_IDLE);

    always_comb
    begin
        case (ctrl.jmp)
            pdc_pkg::JMP_NEXT:      pc_next = pc_reg + 4'd1;
            pdc_pkg::JMP_WAIT_IN:   pc_next = start ? pc_reg + 4'd1 : pc_reg;
            pdc_pkg::JMP_IF_NONNEG: pc_next = status.acc_neg ? pc_reg + 4'd1 : ctrl.target;
            pdc_pkg::JMP_WAIT_OUT:  pc_next = status.out_free ? ctrl.target : pc_reg;
            default:                pc_next = pdc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= pdc_pkg::S_IDLE;
        else
            pc_reg <= pc_next;
    end

endmodule

`default_nettype wire

[hdl/pdc_datapath.sv]
// pdc_datapath: error and integrator update, shared 21x22 multiplier with
// 64-bit accumulator, floor/scale/clamp and the result register. Depends on pdc_pkg.
`default_nettype none

module pdc_datapath (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire pdc_pkg::ctrl_t                   ctrl,
    input  wire pdc_pkg::cfg_t                    cfg,
    input  wire logic                             take,
    input  wire logic signed [pdc_pkg::IN_W-1:0]  reference,
    input  wire logic signed [pdc_pkg::IN_W-1:0]  measured,
    input  wire logic                             result_stall,
    output logic                                  result_valid,
    output logic signed [pdc_pkg::DRV_W-1:0]      drive,
    output logic                                  saturated,
    output pdc_pkg::stat_t                        status
);

    localparam int IN_W   = pdc_pkg::IN_W;
    localparam int ERR_W  = pdc_pkg::ERR_W;
    localparam int DLT_W  = pdc_pkg::DLT_W;
    localparam int INT_W  = pdc_pkg::INT_W;
    localparam int PRE_W  = pdc_pkg::PRE_W;
    localparam int MA_W   = pdc_pkg::MA_W;
    localparam int MB_W   = pdc_pkg::MB_W;
    localparam int PROD_W = pdc_pkg::PROD_W;
    localparam int ACC_W  = pdc_pkg::ACC_W;
    localparam int USAT_W = pdc_pkg::USAT_W;
    localparam int HALF_W = pdc_pkg::HALF_W;
    localparam int GAIN_W = pdc_pkg::GAIN_W;
    localparam int WL_W   = pdc_pkg::WL_W;
    localparam int NS_W   = pdc_pkg::NS_W;
    localparam int OL_W   = pdc_pkg::OL_W;
    localparam int DRV_W  = pdc_pkg::DRV_W;
    localparam int FQ     = pdc_pkg::FRAC_Q;
    localparam int FSH    = pdc_pkg::FLOOR_SH;
    localparam logic signed [IN_W-1:0] MLIM = IN_W'(pdc_pkg::MEAS_LIMIT);

    // input latch and per-item operands
    logic signed [IN_W-1:0]   ref_reg;
    logic signed [IN_W-1:0]   meas_reg;
    logic signed [ERR_W-1:0]  err_reg;
    logic signed [DLT_W-1:0]  dlt_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [USAT_W-1:0] usat_reg;
    logic                     neg_reg;

    // controller state
    logic signed [INT_W-1:0]  integ_reg;
    logic signed [INT_W-1:0]  integ_next;
    logic signed [ERR_W-1:0]  last_err_reg;

    // result register
    logic                     result_valid_reg;
    logic signed [DRV_W-1:0]  drive_reg;
    logic                     saturated_reg;

    logic signed [IN_W-1:0]   meas_c;
    logic signed [ERR_W-1:0]  err_w;
    logic signed [DLT_W-1:0]  dlt_w;
    logic signed [PRE_W-1:0]  pre_w;
    logic signed [PRE_W-1:0]  wl_s;
    logic signed [INT_W-1:0]  wr_s;

    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  prod_ext;

    logic signed [ACC_W-1:0]  u_w;
    logic signed [USAT_W-1:0] usat_w;
    logic signed [ACC_W-1:0]  v_w;
    logic signed [ACC_W-1:0]  cap_w;
    logic signed [DRV_W-1:0]  drv_w;
    logic                     sat_w;
    logic                     out_free;

    assign out_free        = !result_valid_reg || !result_stall;
    assign status.out_free = out_free;
    assign status.acc_neg  = acc_reg[ACC_W-1];

    assign result_valid = result_valid_reg;
    assign drive        = drive_reg;
    assign saturated    = saturated_reg;

    // error, derivative difference and integrator with windup reload
    always_comb
    begin
        if (meas_reg > MLIM)
            meas_c = MLIM;
        else if (meas_reg < -MLIM)
            meas_c = -MLIM;
        else
            meas_c = meas_reg;

        err_w = ERR_W'(ref_reg) - ERR_W'(meas_c);
        dlt_w = DLT_W'(err_w) - DLT_W'(last_err_reg);
        pre_w = PRE_W'(integ_reg) + PRE_W'(err_w);
        wl_s  = $signed({{(PRE_W-WL_W){1'b0}}, cfg.windup_limit});
        wr_s  = $signed({{(INT_W-WL_W){1'b0}}, cfg.windup_reload});

        if (pre_w > wl_s)
            integ_next = wr_s;
        else if (pre_w < -wl_s)
            integ_next = -wr_s;
        else
            integ_next = pre_w[INT_W-1:0];
    end

    // shared multiplier; 40-bit gains are taken as signed high half and
    // unsigned low half
    always_comb
    begin
        case (ctrl.a_sel)
            pdc_pkg::A_KP_HI: mul_a = $signed({cfg.kp_gain[GAIN_W-1],
                                               cfg.kp_gain[GAIN_W-1:HALF_W]});
            pdc_pkg::A_KP_LO: mul_a = $signed({1'b0, cfg.kp_gain[HALF_W-1:0]});
            pdc_pkg::A_KI_HI: mul_a = $signed({cfg.ki_dt_gain[GAIN_W-1],
                                               cfg.ki_dt_gain[GAIN_W-1:HALF_W]});
            pdc_pkg::A_KI_LO: mul_a = $signed({1'b0, cfg.ki_dt_gain[HALF_W-1:0]});
            pdc_pkg::A_KD_HI: mul_a = $signed({cfg.kd_over_dt_gain[GAIN_W-1],
                                               cfg.kd_over_dt_gain[GAIN_W-1:HALF_W]});
            pdc_pkg::A_KD_LO: mul_a = $signed({1'b0, cfg.kd_over_dt_gain[HALF_W-1:0]});
            pdc_pkg::A_NS:    mul_a = $signed({{(MA_W-NS_W){1'b0}}, cfg.neg_scale});
            default:          mul_a = '0;
        endcase

        case (ctrl.b_sel)
            pdc_pkg::B_ERR:  mul_b = MB_W'(err_reg);
            pdc_pkg::B_SUM:  mul_b = MB_W'(integ_reg);
            pdc_pkg::B_DLT:  mul_b = MB_W'(dlt_reg);
            pdc_pkg::B_U_HI: mul_b = MB_W'($signed(usat_reg[USAT_W-1:HALF_W]));
            pdc_pkg::B_U_LO: mul_b = $signed({{(MB_W-HALF_W){1'b0}}, usat_reg[HALF_W-1:0]});
            default:         mul_b = '0;
        endcase

        prod = mul_a * mul_b;
        if (ctrl.hi)
            prod_ext = $signed({prod[PROD_W-1], prod, {HALF_W{1'b0}}});
        else
            prod_ext = ACC_W'(prod);
        acc_next = (ctrl.clr ? '0 : acc_reg) + prod_ext;
    end

    // Q.24 -> Q.16 floor; negative values pinned to 41 bits for scaling,
    // far enough below any drive limit that the clamp result is unchanged
    always_comb
    begin
        u_w = acc_reg >>> FSH;
        if (&u_w[ACC_W-1:USAT_W-1])
            usat_w = u_w[USAT_W-1:0];
        else
            usat_w = $signed({1'b1, {(USAT_W-1){1'b0}}});

        v_w   = neg_reg ? (acc_reg >>> FSH) : acc_reg;
        cap_w = $signed({{(ACC_W-OL_W-FQ){1'b0}}, cfg.out_limit, {FQ{1'b0}}});
        if (v_w > cap_w)
        begin
            drv_w = cap_w[DRV_W-1:0];
            sat_w = 1'b1;
        end
        else if (v_w < -cap_w)
        begin
            drv_w = DRV_W'(-cap_w);
            sat_w = 1'b1;
        end
        else
        begin
            drv_w = v_w[DRV_W-1:0];
            sat_w = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ref_reg  <= reference;
            meas_reg <= measured;
        end
        case (ctrl.op)
            pdc_pkg::OP_LOAD:
            begin
                err_reg <= err_w;
                dlt_reg <= dlt_w;
            end
            pdc_pkg::OP_MAC:
            begin
                acc_reg <= acc_next;
            end
            pdc_pkg::OP_FLOOR:
            begin
                acc_reg  <= u_w;
                usat_reg <= usat_w;
                neg_reg  <= acc_reg[ACC_W-1];
            end
            default:
            begin
            end
        endcase
        if (ctrl.op == pdc_pkg::OP_DONE && out_free)
        begin
            drive_reg     <= drv_w;
            saturated_reg <= sat_w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg        <= '0;
            last_err_reg     <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.op == pdc_pkg::OP_LOAD)
            begin
                integ_reg    <= integ_next;
                last_err_reg <= err_w;
            end
            if (ctrl.op == pdc_pkg::OP_DONE && out_free)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

endmodule

`default_nettype wire

[hdl/pid_drive_controller.sv]
// pid_drive_controller: top level of the microcoded PID drive controller.
// Depends on pdc_pkg, pdc_cfg_regs, pdc_sequencer, pdc_datapath.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+-------------------------------
//  sample   | in        | sample_valid / sample_stall | reference[15:0], measured[15:0]
//  result   | out       | result_valid / result_stall | drive[31:0], saturated
//  cfg      | in        | cfg_valid / cfg_ready       | cfg_index[2:0], cfg_data[39:0]
//
// A word runs through a 12-step microprogram on one shared 21x22 multiplier:
// six multiply-accumulate steps build the Q.24 sum, two more scale a negative drive.
// A new sample is taken only once the previous one has left the final step (a non-negative
// drive skips the two scaling steps); the result register is loaded in the final step.
// The final step waits while the result register is full and stalled.
// Reset zeroes the integrator and last error and loads the register defaults.
`default_nettype none

module pid_drive_controller (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               sample_valid,
    output logic                                    sample_stall,
    input  wire logic signed [pdc_pkg::IN_W-1:0]    reference,
    input  wire logic signed [pdc_pkg::IN_W-1:0]    measured,
    output logic                                    result_valid,
    input  wire logic                               result_stall,
    output logic signed [pdc_pkg::DRV_W-1:0]        drive,
    output logic                                    saturated,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [pdc_pkg::CIDX_W-1:0]         cfg_index,
    input  wire logic [pdc_pkg::GAIN_W-1:0]         cfg_data
);

    pdc_pkg::cfg_t  cfg;
    pdc_pkg::ctrl_t ctrl;
    pdc_pkg::stat_t status;
    logic           busy;
    logic           take;

    assign sample_stall = busy;
    assign take         = sample_valid && !busy;

    pdc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pdc_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (take),
        .status (status),
        .ctrl   (ctrl),
        .busy   (busy)
    );

    pdc_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .cfg          (cfg),
        .take         (take),
        .reference    (reference),
        .measured     (measured),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .drive        (drive),
        .saturated    (saturated),
        .status       (status)
    );

    logic signed [pdc_pkg::DRV_W-1:0] cap_chk;
    assign cap_chk = $signed({1'b0, cfg.out_limit, {pdc_pkg::FRAC_Q{1'b0}}});

    // accepted sample keeps the sequencer busy on the next cycle
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> sample_stall)
        else $error("sequencer not busy after sample accept");

    // a new result only appears out of the final step
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(ctrl.op == pdc_pkg::OP_DONE))
        else $error("result raised outside final step");

    // a valid drive never leaves the limit band
    a_drive_in_band: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (drive <= cap_chk) && (drive >= -cap_chk))
        else $error("drive outside limit");

    // a saturated result sits exactly on a limit
    a_sat_on_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && saturated) |-> (drive == cap_chk) || (drive == -cap_chk))
        else $error("saturated drive not at limit");

endmodule

`default_nettype wire
